// ===== rtl/nsq_pkg.sv =====
`default_nettype none

package nsq_pkg;

	localparam int unsigned POS_W = 24;
	localparam int unsigned UV_W = 16;
	localparam int unsigned BRD_W = 16;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned LANES = 4;
	localparam logic [3:0] LAST_SLICE = 4'd8;
	localparam logic [UV_W-1:0] UV_ONE = 16'd32768;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_HIDDEN = 2'd1,
		ST_BORDER = 2'd2,
		ST_ZERO_SPRITE = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [POS_W-1:0] w;
		logic [POS_W-1:0] h;
		logic [BRD_W-1:0] bl;
		logic [BRD_W-1:0] br;
		logic [BRD_W-1:0] bt;
		logic [BRD_W-1:0] bb;
		logic [UV_W-1:0] u0;
		logic [UV_W-1:0] v0;
		logic [UV_W-1:0] u1;
		logic [UV_W-1:0] v1;
		status_t status;
		logic nine;
	} side_t;

	typedef struct packed {
		logic [BRD_W-1:0] rem;
		logic [DIV_STEPS-1:0] nq;
		logic [BRD_W-1:0] dvs;
		logic neg;
	} lane_t;

endpackage

`default_nettype wire

// ===== rtl/nine_slice_quad_generator_unit.sv =====
`default_nettype none

// Nine-slice quad generator. Each accepted item yields one result (simple
// quad, hidden, or error status) or nine nine-slice quads, bottom row first,
// one result per cycle at the output while out_stall is low. The path is one
// setup stage, a 32-stage one-bit-per-stage divider (four lanes for the
// inner texture edges) and the output holding register. Single-result items
// flow at one item per cycle unless the output stalls; in nine-slice mode an
// item waits in the pipe until the single output port takes the last quad.
module nine_slice_quad_generator_unit
	import nsq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [23:0] rect_x,
	input  wire logic signed [23:0] rect_y,
	input  wire logic [23:0] rect_width,
	input  wire logic [23:0] rect_height,
	input  wire logic [63:0] borders_packed,
	input  wire logic [31:0] sprite_size_packed,
	input  wire logic [63:0] uv_packed,
	input  wire logic slice_mode,
	input  wire logic visible,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [23:0] quad_x,
	output logic signed [23:0] quad_y,
	output logic [23:0] quad_width,
	output logic [23:0] quad_height,
	output logic [15:0] tex_u_min,
	output logic [15:0] tex_v_min,
	output logic [15:0] tex_u_max,
	output logic [15:0] tex_v_max,
	output logic [3:0] slice_number,
	output logic [1:0] status,
	output logic last
);

	side_t side_s [0:DIV_STEPS];
	lane_t lane_s [0:DIV_STEPS][LANES];
	logic vld_s [0:DIV_STEPS];

	logic pipe_en, load, out_acc;

	// hold register
	logic hv_q, single_q;
	status_t st_q;
	logic [3:0] cnt_q;
	logic signed [POS_W-1:0] xe_q [3], ye_q [3];
	logic [POS_W-1:0] wd_q [3], ht_q [3];
	logic [UV_W-1:0] ut_q [4], vt_q [4];

	assign out_acc = out_valid && !out_stall;
	assign load = vld_s[DIV_STEPS] && (!hv_q || (out_acc && last));
	assign pipe_en = !vld_s[DIV_STEPS] || load;
	assign in_stall = !pipe_en;

	// setup stage
	side_t side_in;
	lane_t lane_in [LANES];
	logic [15:0] bl, br, bt, bb, sw, sh, u0, v0, u1, v1;
	logic signed [16:0] du, dv, mu, mv;
	logic [15:0] adu, adv, amu, amv;
	logic [16:0] bsum_x, bsum_y;

	always_comb begin
		bl = borders_packed[15:0];
		br = borders_packed[31:16];
		bt = borders_packed[47:32];
		bb = borders_packed[63:48];
		sw = sprite_size_packed[15:0];
		sh = sprite_size_packed[31:16];
		u0 = uv_packed[15:0];
		v0 = uv_packed[31:16];
		u1 = uv_packed[47:32];
		v1 = uv_packed[63:48];
		du = $signed({1'b0, u1}) - $signed({1'b0, u0});
		dv = $signed({1'b0, v1}) - $signed({1'b0, v0});
		mu = $signed({1'b0, sw}) - $signed({1'b0, br});
		mv = $signed({1'b0, sh}) - $signed({1'b0, bt});
		adu = du[16] ? 16'(-du) : du[15:0];
		adv = dv[16] ? 16'(-dv) : dv[15:0];
		amu = mu[16] ? 16'(-mu) : mu[15:0];
		amv = mv[16] ? 16'(-mv) : mv[15:0];
		bsum_x = {1'b0, bl} + {1'b0, br};
		bsum_y = {1'b0, bt} + {1'b0, bb};

		side_in.x = rect_x;
		side_in.y = rect_y;
		side_in.w = rect_width;
		side_in.h = rect_height;
		side_in.bl = bl;
		side_in.br = br;
		side_in.bt = bt;
		side_in.bb = bb;
		side_in.u0 = u0;
		side_in.v0 = v0;
		side_in.u1 = u1;
		side_in.v1 = v1;
		side_in.nine = slice_mode;
		if (!visible)
			side_in.status = ST_HIDDEN;
		else if (!slice_mode)
			side_in.status = ST_OK;
		else if ({bsum_x, 8'd0} > {1'b0, rect_width} || {bsum_y, 8'd0} > {1'b0, rect_height})
			side_in.status = ST_BORDER;
		else if (sw == '0 || sh == '0)
			side_in.status = ST_ZERO_SPRITE;
		else
			side_in.status = ST_OK;

		lane_in[0].nq = adu * bl;
		lane_in[0].neg = du[16];
		lane_in[0].dvs = sw;
		lane_in[1].nq = adu * amu;
		lane_in[1].neg = du[16] ^ mu[16];
		lane_in[1].dvs = sw;
		lane_in[2].nq = adv * bb;
		lane_in[2].neg = dv[16];
		lane_in[2].dvs = sh;
		lane_in[3].nq = adv * amv;
		lane_in[3].neg = dv[16] ^ mv[16];
		lane_in[3].dvs = sh;
		for (int i = 0; i < LANES; i++)
			lane_in[i].rem = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (pipe_en)
			vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s[0] <= side_in;
			for (int i = 0; i < LANES; i++)
				lane_s[0][i] <= lane_in[i];
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		lane_t nxt [LANES];

		always_comb begin
			for (int i = 0; i < LANES; i++) begin
				logic [16:0] trial;
				trial = {lane_s[k-1][i].rem, lane_s[k-1][i].nq[DIV_STEPS-1]};
				nxt[i] = lane_s[k-1][i];
				if (trial >= {1'b0, lane_s[k-1][i].dvs}) begin
					nxt[i].rem = 16'(trial - {1'b0, lane_s[k-1][i].dvs});
					nxt[i].nq = {lane_s[k-1][i].nq[DIV_STEPS-2:0], 1'b1};
				end else begin
					nxt[i].rem = trial[15:0];
					nxt[i].nq = {lane_s[k-1][i].nq[DIV_STEPS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (pipe_en)
				vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				side_s[k] <= side_s[k-1];
				for (int i = 0; i < LANES; i++)
					lane_s[k][i] <= nxt[i];
			end
		end
	end

	// final edges
	side_t sf;
	logic [UV_W-1:0] tq [LANES];
	logic [UV_W-1:0] cu0, cv0, cu1, cv1;
	logic signed [POS_W-1:0] xe1, xe2, ye1, ye2;

	function automatic logic [UV_W-1:0] clamp_uv(input logic signed [33:0] v);
		if (v < 0)
			return '0;
		else if (v > 34'sd32768)
			return UV_ONE;
		else
			return v[UV_W-1:0];
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [25:0] v);
		if (v > 26'sd8388607)
			return 24'sh7FFFFF;
		else if (v < -26'sd8388608)
			return 24'sh800000;
		else
			return v[POS_W-1:0];
	endfunction

	always_comb begin
		sf = side_s[DIV_STEPS];
		for (int i = 0; i < LANES; i++) begin
			logic signed [33:0] q, base;
			q = lane_s[DIV_STEPS][i].neg ? -$signed({2'b0, lane_s[DIV_STEPS][i].nq})
				: $signed({2'b0, lane_s[DIV_STEPS][i].nq});
			base = (i < 2) ? $signed({18'd0, sf.u0}) : $signed({18'd0, sf.v0});
			tq[i] = clamp_uv(base + q);
		end
		cu0 = clamp_uv($signed({18'd0, sf.u0}));
		cv0 = clamp_uv($signed({18'd0, sf.v0}));
		cu1 = clamp_uv($signed({18'd0, sf.u1}));
		cv1 = clamp_uv($signed({18'd0, sf.v1}));
		xe1 = clamp_pos(26'(sf.x) + $signed({2'b0, sf.bl, 8'd0}));
		xe2 = clamp_pos(26'(sf.x) + $signed({2'b0, sf.w}) - $signed({2'b0, sf.br, 8'd0}));
		ye1 = clamp_pos(26'(sf.y) + $signed({2'b0, sf.bb, 8'd0}));
		ye2 = clamp_pos(26'(sf.y) + $signed({2'b0, sf.h}) - $signed({2'b0, sf.bt, 8'd0}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			hv_q <= 1'b1;
			cnt_q <= '0;
		end else if (out_acc) begin
			if (last)
				hv_q <= 1'b0;
			else
				cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			st_q <= sf.status;
			single_q <= !sf.nine || sf.status != ST_OK;
			for (int i = 0; i < 3; i++) begin
				xe_q[i] <= '0;
				ye_q[i] <= '0;
				wd_q[i] <= '0;
				ht_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				ut_q[i] <= '0;
				vt_q[i] <= '0;
			end
			if (sf.status == ST_OK) begin
				xe_q[0] <= sf.x;
				ye_q[0] <= sf.y;
				ut_q[0] <= cu0;
				vt_q[0] <= cv0;
				if (!sf.nine) begin
					wd_q[0] <= sf.w;
					ht_q[0] <= sf.h;
					ut_q[1] <= cu1;
					vt_q[1] <= cv1;
				end else begin
					xe_q[1] <= xe1;
					xe_q[2] <= xe2;
					ye_q[1] <= ye1;
					ye_q[2] <= ye2;
					wd_q[0] <= {sf.bl[15:0], 8'd0};
					wd_q[1] <= 24'(sf.w - {sf.bl, 8'd0} - {sf.br, 8'd0});
					wd_q[2] <= {sf.br[15:0], 8'd0};
					ht_q[0] <= {sf.bb[15:0], 8'd0};
					ht_q[1] <= 24'(sf.h - {sf.bb, 8'd0} - {sf.bt, 8'd0});
					ht_q[2] <= {sf.bt[15:0], 8'd0};
					ut_q[1] <= tq[0];
					ut_q[2] <= tq[1];
					ut_q[3] <= cu1;
					vt_q[1] <= tq[2];
					vt_q[2] <= tq[3];
					vt_q[3] <= cv1;
				end
			end
		end
	end

	// output select
	logic [1:0] row, col;

	always_comb begin
		case (cnt_q)
			4'd0: begin row = 2'd0; col = 2'd0; end
			4'd1: begin row = 2'd0; col = 2'd1; end
			4'd2: begin row = 2'd0; col = 2'd2; end
			4'd3: begin row = 2'd1; col = 2'd0; end
			4'd4: begin row = 2'd1; col = 2'd1; end
			4'd5: begin row = 2'd1; col = 2'd2; end
			4'd6: begin row = 2'd2; col = 2'd0; end
			4'd7: begin row = 2'd2; col = 2'd1; end
			4'd8: begin row = 2'd2; col = 2'd2; end
			default: begin row = 2'd0; col = 2'd0; end
		endcase
	end

	assign out_valid = hv_q;
	assign quad_x = xe_q[col];
	assign quad_y = ye_q[row];
	assign quad_width = wd_q[col];
	assign quad_height = ht_q[row];
	assign tex_u_min = ut_q[col];
	assign tex_u_max = ut_q[col + 2'd1];
	assign tex_v_min = vt_q[row];
	assign tex_v_max = vt_q[row + 2'd1];
	assign slice_number = cnt_q;
	assign status = st_q;
	assign last = single_q || cnt_q == LAST_SLICE;

`ifndef SYNTHESIS
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last)
		else $error("error status not on a single result");
	a_slice_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> slice_number <= LAST_SLICE)
		else $error("slice number out of range");
	a_slice_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
			out_valid && slice_number == $past(slice_number) + 4'd1)
		else $error("nine-slice sequence broken");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !hv_q || (out_acc && last))
		else $error("held item overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/nine_slice_quad_generator_unit_test.sv =====
`timescale 1ns / 100ps

import nsq_pkg::*;

typedef struct {
	logic signed [23:0] x;
	logic signed [23:0] y;
	logic [23:0] w;
	logic [23:0] h;
	logic [15:0] u0;
	logic [15:0] v0;
	logic [15:0] u1;
	logic [15:0] v1;
	logic [3:0] slice;
	status_t st;
	logic lst;
} quad_t;

class quad_scoreboard;
	quad_t pending[$];
	int errors;
	int quads_seen;

	function longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function void push_quad(longint x, longint y, longint w, longint h, longint u0,
			longint v0, longint u1, longint v1, int slice, status_t st, bit lst);
		quad_t q;
		q.x = 24'(clamp(x, -8388608, 8388607));
		q.y = 24'(clamp(y, -8388608, 8388607));
		q.w = 24'(clamp(w, 0, 24'hFFFFFF));
		q.h = 24'(clamp(h, 0, 24'hFFFFFF));
		q.u0 = 16'(clamp(u0, 0, 32768));
		q.v0 = 16'(clamp(v0, 0, 32768));
		q.u1 = 16'(clamp(u1, 0, 32768));
		q.v1 = 16'(clamp(v1, 0, 32768));
		q.slice = 4'(slice);
		q.st = st;
		q.lst = lst;
		pending.push_back(q);
	endfunction

	function void note_request(logic signed [23:0] rx, logic signed [23:0] ry,
			logic [23:0] rw, logic [23:0] rh, logic [63:0] brd, logic [31:0] spr,
			logic [63:0] uv, bit nine, bit vis);
		longint x, y, w, h, bl, br, bt, bb, sw, sh, u0, v0, u1, v1;
		longint xe[4], ye[4], ut[4], vt[4];
		x = rx; y = ry; w = rw; h = rh;
		bl = brd[15:0]; br = brd[31:16]; bt = brd[47:32]; bb = brd[63:48];
		sw = spr[15:0]; sh = spr[31:16];
		u0 = uv[15:0]; v0 = uv[31:16]; u1 = uv[47:32]; v1 = uv[63:48];
		if (!vis) begin
			push_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, ST_HIDDEN, 1);
			return;
		end
		if (!nine) begin
			push_quad(x, y, w, h, u0, v0, u1, v1, 0, ST_OK, 1);
			return;
		end
		if ((bl + br) * 256 > w || (bt + bb) * 256 > h) begin
			push_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, ST_BORDER, 1);
			return;
		end
		if (sw == 0 || sh == 0) begin
			push_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, ST_ZERO_SPRITE, 1);
			return;
		end
		xe[0] = x; xe[1] = x + bl * 256; xe[2] = x + w - br * 256; xe[3] = x + w;
		ye[0] = y; ye[1] = y + bb * 256; ye[2] = y + h - bt * 256; ye[3] = y + h;
		ut[0] = u0; ut[1] = u0 + ((u1 - u0) * bl) / sw;
		ut[2] = u0 + ((u1 - u0) * (sw - br)) / sw; ut[3] = u1;
		vt[0] = v0; vt[1] = v0 + ((v1 - v0) * bb) / sh;
		vt[2] = v0 + ((v1 - v0) * (sh - bt)) / sh; vt[3] = v1;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				push_quad(xe[c], ye[r], xe[c+1] - xe[c], ye[r+1] - ye[r], ut[c], vt[r],
					ut[c+1], vt[r+1], r * 3 + c, ST_OK, (r * 3 + c) == 8);
	endfunction

	task report(string what, longint got, longint want);
		$display("MISMATCH %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task check_quad(quad_t g);
		quad_t e;
		quads_seen++;
		if (pending.size() == 0) begin
			report("unexpected quad", g.slice, 0);
			return;
		end
		e = pending.pop_front();
		if (g.x !== e.x) report("quad_x", g.x, e.x);
		if (g.y !== e.y) report("quad_y", g.y, e.y);
		if (g.w !== e.w) report("quad_width", g.w, e.w);
		if (g.h !== e.h) report("quad_height", g.h, e.h);
		if (g.u0 !== e.u0) report("tex_u_min", g.u0, e.u0);
		if (g.v0 !== e.v0) report("tex_v_min", g.v0, e.v0);
		if (g.u1 !== e.u1) report("tex_u_max", g.u1, e.u1);
		if (g.v1 !== e.v1) report("tex_v_max", g.v1, e.v1);
		if (g.slice !== e.slice) report("slice_number", g.slice, e.slice);
		if (g.st !== e.st) report("status", g.st, e.st);
		if (g.lst !== e.lst) report("last", g.lst, e.lst);
	endtask
endclass

module nine_slice_quad_generator_unit_test;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [23:0] rect_x = 0;
	logic signed [23:0] rect_y = 0;
	logic [23:0] rect_width = 0;
	logic [23:0] rect_height = 0;
	logic [63:0] borders_packed = 0;
	logic [31:0] sprite_size_packed = 0;
	logic [63:0] uv_packed = 0;
	logic slice_mode = 0;
	logic visible = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [23:0] quad_x;
	logic signed [23:0] quad_y;
	logic [23:0] quad_width;
	logic [23:0] quad_height;
	logic [15:0] tex_u_min;
	logic [15:0] tex_v_min;
	logic [15:0] tex_u_max;
	logic [15:0] tex_v_max;
	logic [3:0] slice_number;
	logic [1:0] status;
	logic last;

	quad_scoreboard sb = new();
	int cycles = 0;
	int requests = 0;
	int nine_requests = 0;
	bit sending = 1;

	nine_slice_quad_generator_unit dut (.*);

	always #4 clk = ~clk;

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("Test completed with failures");
			$finish;
		end
		if (out_valid && !out_stall) begin
			quad_t g;
			g.x = quad_x; g.y = quad_y; g.w = quad_width; g.h = quad_height;
			g.u0 = tex_u_min; g.v0 = tex_v_min; g.u1 = tex_u_max; g.v1 = tex_v_max;
			g.slice = slice_number; g.st = status_t'(status); g.lst = last;
			sb.check_quad(g);
		end
	end

	// receiver stalls in bursts while sending, never afterward
	initial begin
		int n;
		@(posedge arst_n);
		while (sending) begin
			n = gap_len();
			@(negedge clk);
			if (n != 0) begin
				out_stall <= 1;
				repeat (n) @(negedge clk);
				out_stall <= 0;
			end
			repeat ($urandom_range(0, 12)) @(negedge clk);
		end
		@(negedge clk);
		out_stall <= 0;
	end

	task send_request(logic [23:0] rx, logic [23:0] ry, logic [23:0] rw, logic [23:0] rh,
			logic [63:0] brd, logic [31:0] spr, logic [63:0] uv, bit nine, bit vis);
		int n;
		rect_x <= rx; rect_y <= ry; rect_width <= rw; rect_height <= rh;
		borders_packed <= brd; sprite_size_packed <= spr; uv_packed <= uv;
		slice_mode <= nine; visible <= vis;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_request(rx, ry, rw, rh, brd, spr, uv, nine, vis);
		requests++;
		if (nine && vis) nine_requests++;
		@(negedge clk);
		n = gap_len();
		if (n != 0) begin
			in_valid <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	function logic [63:0] pack4(int a, int b, int c, int d);
		return {d[15:0], c[15:0], b[15:0], a[15:0]};
	endfunction

	// nine-slice request with random content, mostly well-formed
	task send_random_nine();
		int bl, br, bt, bb, sw, sh;
		logic [23:0] w, h;
		sw = $urandom_range(0, 9) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 64);
		sh = $urandom_range(0, 9) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 64);
		bl = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, sw);
		br = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, sw);
		bt = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, sh);
		bb = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, sh);
		w = 24'((bl + br) * 256 + $urandom_range(0, 3) * ($urandom() & 24'hFFFF));
		h = 24'((bt + bb) * 256 + $urandom_range(0, 3) * ($urandom() & 24'hFFFF));
		if ($urandom_range(0, 7) == 0) w = 24'($urandom());
		if ($urandom_range(0, 7) == 0) h = 24'($urandom());
		if ($urandom_range(0, 15) == 0) sw = 0;
		send_request(24'($urandom()), 24'($urandom()), w, h, pack4(bl, br, bt, bb),
			{sh[15:0], sw[15:0]}, {$urandom(), $urandom()} &
			($urandom_range(0, 3) != 0 ? 64'h7FFF7FFF7FFF7FFF : '1) |
			($urandom_range(0, 5) == 0 ? 64'h8000800080008000 : 64'h0),
			1, $urandom_range(0, 15) != 0);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_request(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_request(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF, '1, '1, '1, 0, 1);
		send_request(24'h800000, 24'h7FFFFF, 0, 0, 0, 0, 0, 0, 1);
		send_request(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, pack4(4, 4, 4, 4),
			{16'd16, 16'd16}, pack4(0, 0, 32768, 32768), 1, 1);
		send_request(24'h800000, 24'h800000, 24'h1000, 24'h1000, pack4(8, 8, 8, 8),
			{16'd16, 16'd16}, pack4(32768, 32768, 0, 0), 1, 1);
		send_request(0, 0, 24'h0FF, 24'h1000, pack4(1, 0, 0, 0), {16'd4, 16'd4},
			pack4(0, 0, 100, 100), 1, 1);
		send_request(0, 0, 24'h1000, 24'h1FF, pack4(0, 0, 1, 1), {16'd4, 16'd4},
			pack4(0, 0, 100, 100), 1, 1);
		send_request(0, 0, 24'h1000, 24'h1000, 0, {16'd4, 16'd0}, 0, 1, 1);
		send_request(0, 0, 24'h1000, 24'h1000, 0, {16'd0, 16'd4}, 0, 1, 1);
		send_request(5, 7, 24'h200, 24'h200, pack4(1, 1, 1, 1), {16'd1, 16'd1},
			pack4(0, 0, 32768, 32768), 1, 1);
		send_request(0, 0, 24'hFFFFFF, 24'hFFFFFF, pack4(200, 200, 300, 300),
			{16'd100, 16'd100}, pack4(1000, 1000, 65535, 65535), 1, 1);
		send_request(100, 100, 24'h10000, 24'h10000, pack4(3, 5, 7, 2), {16'd9, 16'd11},
			pack4(30000, 20000, 1000, 5000), 1, 0);
		send_request(0, 0, 24'hFFFF00, 24'hFFFF00, '1 >> 1, '1, '1, 1, 1);
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		for (int i = 0; i < 300; i++) begin
			if (i == 150) begin
				in_valid <= 0;
				while (sb.pending.size() != 0) @(negedge clk);
			end
			if ($urandom_range(0, 9) < 7) send_random_nine();
			else send_request(24'($urandom()), 24'($urandom()), 24'($urandom()),
				24'($urandom()), {$urandom(), $urandom()}, $urandom(),
				{$urandom(), $urandom()}, 1'($urandom_range(0, 1)),
				$urandom_range(0, 4) != 0);
		end
		in_valid <= 0;
		sending = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		$display("Sent %0d requests (%0d nine-slice), checked %0d quads.",
			requests, nine_requests, sb.quads_seen);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/nsq_pkg.sv
rtl/nine_slice_quad_generator_unit.sv
tb/nine_slice_quad_generator_unit_test.sv
